// ----- hw/rtl/sbru_pkg.sv -----
// sbru_pkg: shared types, constants and helper functions for the
// spin-sector basis rank/unrank block. Depends on nothing.
`default_nettype none

package sbru_pkg;

  localparam int unsigned MaxSites  = 16;
  localparam int unsigned CodeW     = 32;
  localparam int unsigned CountW    = 33;
  localparam int unsigned WaysW     = 17;
  localparam int unsigned BinomW    = 14;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 5;

  // register indexes on the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SITE_COUNT     = 3'd0,
    CFG_UP_FILTER_ON   = 3'd1,
    CFG_UP_TARGET      = 3'd2,
    CFG_DOWN_FILTER_ON = 3'd3,
    CFG_DOWN_TARGET    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_RANK   = 1'b0,
    OP_UNRANK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        op;
    logic [31:0] query_code;
    logic [31:0] query_position;
  } in_item_t;

  typedef struct packed {
    logic [31:0] found_position;
    logic [31:0] found_code;
    logic        found;
    logic [32:0] basis_count;
  } out_item_t;

  typedef struct packed {
    logic [4:0] site_count;
    logic       up_filter_on;
    logic [4:0] up_target;
    logic       down_filter_on;
    logic [4:0] down_target;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  typedef logic [MaxSites:0][MaxSites:0][BinomW-1:0] binom_tab_t;

  // pascal triangle, evaluated at elaboration
  function automatic binom_tab_t build_binom();
    binom_tab_t t;
    t = '0;
    for (int n = 0; n <= int'(MaxSites); n++) begin
      t[n][0] = BinomW'(1);
      for (int k = 1; k <= n; k++) begin
        t[n][k] = BinomW'(t[n-1][k-1] + t[n-1][k]);
      end
    end
    return t;
  endfunction

  localparam binom_tab_t Binom = build_binom();

  // fill counts for n free sites of one spin kind
  function automatic logic [WaysW-1:0] ways(logic [4:0] n, logic on,
                                            logic [4:0] target, logic [4:0] used);
    logic [4:0]       k;
    logic [WaysW-1:0] r;
    k = target - used;
    if (!on) begin
      r = WaysW'(1) << n;
    end else if ((used > target) || (k > n)) begin
      r = '0;
    end else begin
      r = WaysW'(Binom[n][k]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sector_basis_rank_unrank.sv -----
// sector_basis_rank_unrank: rank/unrank of spin-sector occupation codes.
// A transaction walks a MUL and an UPD state for the count step and then for
// each code bit (2N bits, N effective sites) before the result strobe in ST_DONE.
// A new start is taken only in ST_IDLE; busy stays high until the walk is over.
// Reset: asynchronous active low; site_count returns to 1, other cfg fields to 0.
// The receiver cannot stall; the result strobe lasts one cycle.
`default_nettype none

module sector_basis_rank_unrank
  import sbru_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire in_item_t            in_i,
  output logic                     done_o,
  output out_item_t                result_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{site_count: 5'd1, default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SITE_COUNT:     cfg_q.site_count     <= cfg_data_i;
        CFG_UP_FILTER_ON:   cfg_q.up_filter_on   <= cfg_data_i[0];
        CFG_UP_TARGET:      cfg_q.up_target      <= cfg_data_i;
        CFG_DOWN_FILTER_ON: cfg_q.down_filter_on <= cfg_data_i[0];
        CFG_DOWN_TARGET:    cfg_q.down_target    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sbru_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  sbru_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .cfg_i    (cfg_q),
    .item_i   (in_i),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/sbru_ctrl.sv -----
// sbru_ctrl: sequencing state machine for the rank/unrank walk.
// Depends on sbru_pkg; drives sbru_datapath through cmd_t.
`default_nettype none

module sbru_ctrl
  import sbru_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  output logic         done_o,
  output cmd_t         cmd_o,
  input  wire status_t status_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_UPD;
      ST_UPD: begin
        state_d = status_i.last ? ST_DONE : ST_MUL;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_q != ST_IDLE);
    done_o     = (state_q == ST_DONE);
    cmd_o.load = (state_q == ST_IDLE) && start;
    cmd_o.mul  = (state_q == ST_MUL);
    cmd_o.upd  = (state_q == ST_UPD);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sbru_datapath.sv -----
// sbru_datapath: bit counter, completion-count multiplier and the
// rank/unrank accumulators. Depends on sbru_pkg; commanded by sbru_ctrl.
`default_nettype none

module sbru_datapath
  import sbru_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cmd_t     cmd_i,
  output status_t       status_o,
  input  wire cfg_t     cfg_i,
  input  wire in_item_t item_i,
  output out_item_t     result_o
);

  logic [5:0]        b_q, b_d;
  logic              op_q;
  logic [CodeW-1:0]  code_q;
  logic [CodeW-1:0]  rem_q;
  logic [CodeW-1:0]  acc_q;
  logic [CountW-1:0] prod_q;
  logic [CountW-1:0] count_q;
  logic              pos_ok_q;
  logic [4:0]        used_up_q, used_dn_q;

  logic [4:0]       n_eff;
  logic [5:0]       bits;
  logic [WaysW-1:0] ways_up, ways_dn;
  logic [5:0]       b_plus1;
  logic [4:0]       bit_idx;
  logic             take;
  logic             first;
  logic             hi_ok, up_ok, dn_ok, found;

  always_comb begin
    if (cfg_i.site_count == 5'd0) begin
      n_eff = 5'd1;
    end else if (cfg_i.site_count > 5'(MaxSites)) begin
      n_eff = 5'(MaxSites);
    end else begin
      n_eff = cfg_i.site_count;
    end
  end

  assign bits    = {n_eff, 1'b0};
  assign first   = (b_q == bits);
  assign b_plus1 = b_q + 6'd1;
  assign bit_idx = b_q[4:0];

  // completions below bit b: up sites (b+1)/2, down sites b/2
  assign ways_up = ways(b_plus1[5:1], cfg_i.up_filter_on, cfg_i.up_target, used_up_q);
  assign ways_dn = ways(b_q[5:1], cfg_i.down_filter_on, cfg_i.down_target, used_dn_q);

  assign take = (op_q == OP_UNRANK) ? ({1'b0, rem_q} >= prod_q) : code_q[bit_idx];

  always_comb begin
    b_d = b_q;
    if (cmd_i.load) begin
      b_d = bits;
    end else if (cmd_i.upd && (b_q != 6'd0)) begin
      b_d = b_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else begin
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= item_i.op;
      code_q    <= item_i.query_code;
      rem_q     <= item_i.query_position;
      acc_q     <= '0;
      used_up_q <= '0;
      used_dn_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= CountW'(ways_up) * CountW'(ways_dn);
    end
    if (cmd_i.upd) begin
      if (first) begin
        count_q  <= prod_q;
        pos_ok_q <= ({1'b0, rem_q} < prod_q);
      end else if (take) begin
        if (op_q == OP_UNRANK) begin
          rem_q <= rem_q - prod_q[CodeW-1:0];
          acc_q <= acc_q | (CodeW'(1) << bit_idx);
        end else begin
          acc_q <= acc_q + prod_q[CodeW-1:0];
        end
        // even bits are up sites, odd bits down sites
        if (bit_idx[0]) begin
          used_dn_q <= used_dn_q + 5'd1;
        end else begin
          used_up_q <= used_up_q + 5'd1;
        end
      end
    end
  end

  assign status_o.last = (b_q == 6'd0);

  assign hi_ok = ((code_q >> bits) == '0);
  assign up_ok = !cfg_i.up_filter_on || (used_up_q == cfg_i.up_target);
  assign dn_ok = !cfg_i.down_filter_on || (used_dn_q == cfg_i.down_target);
  assign found = (op_q == OP_UNRANK) ? pos_ok_q : (hi_ok && up_ok && dn_ok);

  always_comb begin
    result_o.found          = found;
    result_o.basis_count    = count_q;
    result_o.found_position = (found && (op_q == OP_RANK)) ? acc_q : '0;
    result_o.found_code     = (found && (op_q == OP_UNRANK)) ? acc_q : '0;
  end

endmodule

`default_nettype wire
